[rtl/core/dmjc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dmjc_pkg;

   // Longest run window that a start item may arm.
   localparam logic [15:0] MaxRunMs = 16'd60000;

   // Operation codes carried by an input item.
   typedef enum logic [1:0] {
      OpTick     = 2'd0,
      OpRun      = 2'd1,
      OpDispense = 2'd2,
      OpStop     = 2'd3
   } op_type;

   // Result codes reported with every result item.
   typedef enum logic [2:0] {
      ResNone    = 3'd0,
      ResRunning = 3'd1,
      ResDone    = 3'd2,
      ResTimeout = 3'd3,
      ResJam     = 3'd4,
      ResAborted = 3'd5,
      ResRefused = 3'd6
   } result_type;

   // Motor bridge drive codes.
   typedef enum logic [1:0] {
      DriveOff  = 2'd0,
      DriveOne  = 2'd1,
      DriveZero = 2'd2
   } drive_type;

   // Operation mode of the controller.
   typedef enum logic [1:0] {
      ModeIdle     = 2'd0,
      ModeRun      = 2'd1,
      ModeDispense = 2'd2
   } mode_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CsrStallWindow     = 3'd0,
      CsrReverseTime     = 3'd1,
      CsrMaxRetries      = 3'd2,
      CsrChuteRefractory = 3'd3,
      CsrChuteActive     = 3'd4
   } csr_index_type;

   // Configuration reset values.
   localparam logic [15:0] StallWindowReset     = 16'd0;
   localparam logic [15:0] ReverseTimeReset     = 16'd400;
   localparam logic [3:0]  MaxRetriesReset      = 4'd3;
   localparam logic [15:0] ChuteRefractoryReset = 16'd1000;
   localparam logic        ChuteActiveReset     = 1'b1;

   typedef struct packed {
      logic [15:0] stall_window_ms;
      logic [15:0] reverse_time_ms;
      logic [3:0]  max_retries;
      logic [15:0] chute_refractory_ms;
      logic        chute_active_level;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] now_ms;
      logic        rotor_level;
      logic        chute_level;
      logic [15:0] motor_ma;
      logic        emitters_ok;
      logic        direction;
      logic [31:0] run_ms;
      logic [15:0] jam_threshold_ma;
      logic [7:0]  parcel_target;
   } req_type;

   typedef struct packed {
      logic [1:0]  motor_drive;
      logic        busy_res;
      logic [2:0]  result_code;
      logic        recovering;
      logic [7:0]  parcels_delivered;
      logic [15:0] revolutions;
      logic [15:0] peak_current_ma;
      logic [3:0]  retries_used;
   } rsp_type;

   typedef struct packed {
      mode_type    mode;
      drive_type   drive;
      logic        forward_dir;
      logic        reverse_phase;
      logic [31:0] deadline;
      logic [31:0] phase_end;
      logic [7:0]  target_count;
      logic [7:0]  parcel_count;
      logic [15:0] rev_count;
      logic        rotor_prev;
      logic        chute_prev;
      logic [31:0] last_advance;
      logic [31:0] chute_lock_until;
      logic [15:0] jam_limit;
      logic [3:0]  retry_count;
      logic [15:0] peak_current;
      result_type  result;
   } state_type;

endpackage

`default_nettype wire

[rtl/core/dmjc_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none

// Input item channel.
interface dmjc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [31:0] now_ms;
   logic        rotor_level;
   logic        chute_level;
   logic [15:0] motor_ma;
   logic        emitters_ok;
   logic        direction;
   logic [31:0] run_ms;
   logic [15:0] jam_threshold_ma;
   logic [7:0]  parcel_target;

   modport source (
      output valid, operation, now_ms, rotor_level, chute_level, motor_ma,
             emitters_ok, direction, run_ms, jam_threshold_ma, parcel_target,
      input  ready
   );
   modport sink (
      input  valid, operation, now_ms, rotor_level, chute_level, motor_ma,
             emitters_ok, direction, run_ms, jam_threshold_ma, parcel_target,
      output ready
   );
endinterface

// Result item channel.
interface dmjc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  motor_drive;
   logic        busy_res;
   logic [2:0]  result_code;
   logic        recovering;
   logic [7:0]  parcels_delivered;
   logic [15:0] revolutions;
   logic [15:0] peak_current_ma;
   logic [3:0]  retries_used;

   modport source (
      output valid, motor_drive, busy_res, result_code, recovering,
             parcels_delivered, revolutions, peak_current_ma, retries_used,
      input  ready
   );
   modport sink (
      input  valid, motor_drive, busy_res, result_code, recovering,
             parcels_delivered, revolutions, peak_current_ma, retries_used,
      output ready
   );
endinterface

// Configuration write channel.
interface dmjc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/dmjc_csr.sv]
`timescale 1ns / 1ps
`default_nettype none

module dmjc_csr (
   input  wire logic              clock,
   input  wire logic              reset,
   dmjc_csr_if.sink               csr,
   output dmjc_pkg::cfg_type      cfg
);

   dmjc_pkg::cfg_type cfg_ff;
   dmjc_pkg::cfg_type cfg_in;

   // Writes are always taken.
   assign csr.ready = 1'b1;

   // Decode the register index; unknown indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (dmjc_pkg::csr_index_type'(csr.index))
            dmjc_pkg::CsrStallWindow:     cfg_in.stall_window_ms     = csr.data;
            dmjc_pkg::CsrReverseTime:     cfg_in.reverse_time_ms     = csr.data;
            dmjc_pkg::CsrMaxRetries:      cfg_in.max_retries         = csr.data[3:0];
            dmjc_pkg::CsrChuteRefractory: cfg_in.chute_refractory_ms = csr.data;
            dmjc_pkg::CsrChuteActive:     cfg_in.chute_active_level  = csr.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stall_window_ms     <= dmjc_pkg::StallWindowReset;
         cfg_ff.reverse_time_ms     <= dmjc_pkg::ReverseTimeReset;
         cfg_ff.max_retries         <= dmjc_pkg::MaxRetriesReset;
         cfg_ff.chute_refractory_ms <= dmjc_pkg::ChuteRefractoryReset;
         cfg_ff.chute_active_level  <= dmjc_pkg::ChuteActiveReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[rtl/core/dmjc_step.sv]
`timescale 1ns / 1ps
`default_nettype none

module dmjc_step (
   input  wire dmjc_pkg::state_type state,
   input  wire dmjc_pkg::cfg_type   cfg,
   input  wire dmjc_pkg::req_type   item,
   output dmjc_pkg::state_type      state_next,
   output dmjc_pkg::rsp_type        result
);

   // True once the wrapping timestamp has reached the mark.
   function automatic logic reached(input logic [31:0] now, input logic [31:0] mark);
      logic [31:0] diff;
      diff = now - mark;
      return ~diff[31];
   endfunction

   // Motor off and controller idle.
   function automatic dmjc_pkg::state_type halt(input dmjc_pkg::state_type s);
      dmjc_pkg::state_type t;
      t = s;
      t.drive = dmjc_pkg::DriveOff;
      t.mode = dmjc_pkg::ModeIdle;
      t.reverse_phase = 1'b0;
      return t;
   endfunction

   // Drive toward a direction, or stop with a refusal when emitter power is bad.
   function automatic dmjc_pkg::state_type drive_dir(input dmjc_pkg::state_type s,
                                                     input logic d, input logic ok);
      dmjc_pkg::state_type t;
      t = s;
      if (!ok) begin
         t = halt(s);
         t.result = dmjc_pkg::ResRefused;
      end else begin
         t.drive = d ? dmjc_pkg::DriveOne : dmjc_pkg::DriveZero;
      end
      return t;
   endfunction

   dmjc_pkg::state_type v;
   dmjc_pkg::op_type    op;
   logic [15:0]         run_clamped;
   logic [31:0]         since;
   logic [7:0]          pc_new;
   logic                parcel_hit;
   logic                jam_i;
   logic                stall;

   assign op = dmjc_pkg::op_type'(item.operation);
   assign run_clamped = (item.run_ms > {16'd0, dmjc_pkg::MaxRunMs}) ?
                        dmjc_pkg::MaxRunMs : item.run_ms[15:0];

   // One item's state update, in the order the controller evaluates it.
   always_comb begin
      v = state;
      since = 32'd0;
      pc_new = state.parcel_count;
      parcel_hit = 1'b0;
      jam_i = 1'b0;
      stall = 1'b0;
      case (op)
         dmjc_pkg::OpTick: begin
            if (state.drive != dmjc_pkg::DriveOff) begin
               if (item.motor_ma > v.peak_current) begin
                  v.peak_current = item.motor_ma;
               end
               if (reached(item.now_ms, state.deadline)) begin
                  // Run window expired.
                  v.result = (state.mode == dmjc_pkg::ModeDispense) ?
                             dmjc_pkg::ResTimeout : dmjc_pkg::ResDone;
                  v = halt(v);
               end else begin
                  // Rotor rising edge marks an advance.
                  if (item.rotor_level && !state.rotor_prev) begin
                     v.rev_count = v.rev_count + 16'd1;
                     v.last_advance = item.now_ms;
                  end
                  v.rotor_prev = item.rotor_level;
                  if (state.reverse_phase) begin
                     // End of a reverse move resumes forward drive.
                     if (reached(item.now_ms, state.phase_end)) begin
                        v.reverse_phase = 1'b0;
                        v = drive_dir(v, state.forward_dir, item.emitters_ok);
                        v.chute_prev = item.chute_level;
                        v.last_advance = item.now_ms;
                     end
                  end else begin
                     // Chute edge into the active level counts a parcel.
                     parcel_hit = (state.mode == dmjc_pkg::ModeDispense) &&
                                  (item.chute_level == cfg.chute_active_level) &&
                                  (state.chute_prev != cfg.chute_active_level) &&
                                  reached(item.now_ms, state.chute_lock_until);
                     if (parcel_hit) begin
                        pc_new = (state.parcel_count != 8'hFF) ?
                                 state.parcel_count + 8'd1 : state.parcel_count;
                        v.parcel_count = pc_new;
                        v.chute_lock_until = item.now_ms + {16'd0, cfg.chute_refractory_ms};
                     end
                     if (parcel_hit && (pc_new >= state.target_count)) begin
                        v.result = dmjc_pkg::ResDone;
                        v = halt(v);
                     end else begin
                        v.chute_prev = item.chute_level;
                        jam_i = (state.jam_limit != 16'd0) &&
                                (item.motor_ma > state.jam_limit);
                        if (state.mode == dmjc_pkg::ModeDispense) begin
                           // Current or stall jam: reverse, or give up at the limit.
                           since = item.now_ms - v.last_advance;
                           stall = (cfg.stall_window_ms != 16'd0) && !since[31] &&
                                   (since > {16'd0, cfg.stall_window_ms});
                           if (jam_i || stall) begin
                              if (state.retry_count >= cfg.max_retries) begin
                                 v.result = dmjc_pkg::ResJam;
                                 v = halt(v);
                              end else begin
                                 v.retry_count = state.retry_count + 4'd1;
                                 v.reverse_phase = 1'b1;
                                 v.phase_end = item.now_ms + {16'd0, cfg.reverse_time_ms};
                                 v = drive_dir(v, ~state.forward_dir, item.emitters_ok);
                                 v.last_advance = item.now_ms;
                              end
                           end
                        end else if (jam_i) begin
                           v.result = dmjc_pkg::ResJam;
                           v = halt(v);
                        end
                     end
                  end
               end
            end
         end
         dmjc_pkg::OpStop: begin
            v = halt(v);
            v.result = dmjc_pkg::ResAborted;
         end
         dmjc_pkg::OpRun, dmjc_pkg::OpDispense: begin
            // Start restarts the operation from scratch.
            v.mode = (op == dmjc_pkg::OpDispense) ? dmjc_pkg::ModeDispense : dmjc_pkg::ModeRun;
            v.reverse_phase = 1'b0;
            v.forward_dir = item.direction;
            v.target_count = (op == dmjc_pkg::OpDispense) ? item.parcel_target : 8'd0;
            v.parcel_count = 8'd0;
            v.rev_count = 16'd0;
            v.retry_count = 4'd0;
            v.peak_current = 16'd0;
            v.chute_lock_until = 32'd0;
            v.jam_limit = item.jam_threshold_ma;
            v.result = dmjc_pkg::ResRunning;
            v.deadline = item.now_ms + {16'd0, run_clamped};
            v.last_advance = item.now_ms;
            v = drive_dir(v, item.direction, item.emitters_ok);
            v.rotor_prev = item.rotor_level;
            v.chute_prev = item.chute_level;
         end
         default: ;
      endcase
   end

   assign state_next = v;

   // Result fields come from the updated state.
   assign result.motor_drive       = v.drive;
   assign result.busy_res          = (v.drive != dmjc_pkg::DriveOff);
   assign result.result_code       = v.result;
   assign result.recovering        = v.reverse_phase;
   assign result.parcels_delivered = v.parcel_count;
   assign result.revolutions       = v.rev_count;
   assign result.peak_current_ma   = v.peak_current;
   assign result.retries_used      = v.retry_count;

endmodule

`default_nettype wire

[rtl/core/dispense_motor_jam_controller.sv]
`timescale 1ns / 1ps
`default_nettype none

// Feeder motor controller with jam recovery.
// Items arrive on req: start a timed run, start a dispense, tick with a
// timestamp and sensor samples, or stop. Every accepted item yields exactly
// one result item on rsp with the motor drive, result code, counters and
// peak current after that item. The user is to write registers on csr by
// index only while the block is idle; the block itself does not enforce this;
// writes are always taken. An accepted item lands in the input register, and
// its result is registered in the result register once that is free, which
// raises rsp.valid. Throughput: one item per cycle while rsp does not stall,
// set by the combinational state update between the input register and the
// state and result registers.
// When rsp stalls, the result register holds and the input register takes
// one more item; req.ready drops only when both are full.
// Reset clears the state to idle with motor off and result none, loads the
// register defaults and empties both pipeline registers.
module dispense_motor_jam_controller (
   input  wire logic clock,
   input  wire logic reset,
   dmjc_req_if.sink  req,
   dmjc_rsp_if.source rsp,
   dmjc_csr_if.sink  csr
);

   dmjc_pkg::cfg_type   cfg;
   dmjc_pkg::req_type   req_ff;
   dmjc_pkg::req_type   req_in;
   logic                req_valid_ff;
   logic                req_valid_in;
   dmjc_pkg::state_type state_ff;
   dmjc_pkg::state_type state_in;
   dmjc_pkg::rsp_type   rsp_ff;
   dmjc_pkg::rsp_type   rsp_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                advance;
   logic                take;

   dmjc_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .cfg   (cfg)
   );

   dmjc_step u_step (
      .state      (state_ff),
      .cfg        (cfg),
      .item       (req_ff),
      .state_next (state_in),
      .result     (rsp_in)
   );

   // Handshake: the held item moves on when the result register is free.
   assign advance = req_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !req_valid_ff || advance;
   assign take = req.valid && req.ready;

   assign req_in.operation        = req.operation;
   assign req_in.now_ms           = req.now_ms;
   assign req_in.rotor_level      = req.rotor_level;
   assign req_in.chute_level      = req.chute_level;
   assign req_in.motor_ma         = req.motor_ma;
   assign req_in.emitters_ok      = req.emitters_ok;
   assign req_in.direction        = req.direction;
   assign req_in.run_ms           = req.run_ms;
   assign req_in.jam_threshold_ma = req.jam_threshold_ma;
   assign req_in.parcel_target    = req.parcel_target;

   assign req_valid_in = take ? 1'b1 : (advance ? 1'b0 : req_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   // Control registers and controller state.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff              <= 1'b0;
         rsp_valid_ff              <= 1'b0;
         state_ff.mode             <= dmjc_pkg::ModeIdle;
         state_ff.drive            <= dmjc_pkg::DriveOff;
         state_ff.forward_dir      <= 1'b1;
         state_ff.reverse_phase    <= 1'b0;
         state_ff.deadline         <= 32'd0;
         state_ff.phase_end        <= 32'd0;
         state_ff.target_count     <= 8'd0;
         state_ff.parcel_count     <= 8'd0;
         state_ff.rev_count        <= 16'd0;
         state_ff.rotor_prev       <= 1'b0;
         state_ff.chute_prev       <= 1'b0;
         state_ff.last_advance     <= 32'd0;
         state_ff.chute_lock_until <= 32'd0;
         state_ff.jam_limit        <= 16'd0;
         state_ff.retry_count      <= 4'd0;
         state_ff.peak_current     <= 16'd0;
         state_ff.result           <= dmjc_pkg::ResNone;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (take) begin
         req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.motor_drive       = rsp_ff.motor_drive;
   assign rsp.busy_res          = rsp_ff.busy_res;
   assign rsp.result_code       = rsp_ff.result_code;
   assign rsp.recovering        = rsp_ff.recovering;
   assign rsp.parcels_delivered = rsp_ff.parcels_delivered;
   assign rsp.revolutions       = rsp_ff.revolutions;
   assign rsp.peak_current_ma   = rsp_ff.peak_current_ma;
   assign rsp.retries_used      = rsp_ff.retries_used;

endmodule

`default_nettype wire

[tb/sv/dmjc_feeder_checker.sv]
`timescale 1ns / 1ps

// Watches the three channels of the feeder motor controller. Every accepted
// input item is run through a local model of the controller, and the result
// it should produce is queued. Every accepted result item is compared field
// by field with the oldest queued result.
module dmjc_feeder_checker
   import dmjc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   dmjc_req_if        req_mon,
   dmjc_rsp_if        rsp_mon,
   dmjc_csr_if        csr_mon,
   output int         mismatch_count,
   output int         awaiting_count
);

   // Local copy of the controller state.
   typedef struct packed {
      mode_type    mode;
      drive_type   drive;
      logic        fwd;
      logic        reversing;
      logic [31:0] deadline;
      logic [31:0] reverse_end;
      logic [7:0]  target;
      logic [7:0]  parcels;
      logic [15:0] revs;
      logic        rotor_last;
      logic        chute_last;
      logic [31:0] last_move;
      logic [31:0] chute_hold;
      logic [15:0] jam_ma;
      logic [3:0]  retries;
      logic [15:0] peak_ma;
      result_type  status;
   } feeder_state_type;

   feeder_state_type fd;
   cfg_type          settings;
   rsp_type          expected_reports[$];
   rsp_type          want;
   req_type          item;
   int               failures = 0;

   assign mismatch_count = failures;

   // A timestamp has been reached once the wrapped difference is non-negative.
   function automatic logic time_reached(logic [31:0] now, logic [31:0] mark);
      logic [31:0] diff;
      diff = now - mark;
      return !diff[31];
   endfunction

   function automatic void halt_feeder();
      fd.drive     = DriveOff;
      fd.mode      = ModeIdle;
      fd.reversing = 1'b0;
   endfunction

   // Any change of drive is refused when the emitter power is bad.
   function automatic void drive_feeder(logic dir, logic power_ok);
      if (!power_ok) begin
         halt_feeder();
         fd.status = ResRefused;
      end else begin
         fd.drive = dir ? DriveOne : DriveZero;
      end
   endfunction

   // Applies one input item to the local state.
   function automatic void advance_feeder(req_type in_item);
      logic [31:0] window;
      logic [31:0] since;
      logic        current_jam;
      logic        stalled;
      case (op_type'(in_item.operation))
         OpStop: begin
            halt_feeder();
            fd.status = ResAborted;
         end
         OpRun, OpDispense: begin
            window = (in_item.run_ms > {16'd0, MaxRunMs}) ? {16'd0, MaxRunMs}
                                                           : in_item.run_ms;
            fd.mode = (op_type'(in_item.operation) == OpDispense) ? ModeDispense : ModeRun;
            fd.reversing  = 1'b0;
            fd.fwd        = in_item.direction;
            fd.target     = (fd.mode == ModeDispense) ? in_item.parcel_target : 8'd0;
            fd.parcels    = 8'd0;
            fd.revs       = 16'd0;
            fd.retries    = 4'd0;
            fd.peak_ma    = 16'd0;
            fd.chute_hold = 32'd0;
            fd.jam_ma     = in_item.jam_threshold_ma;
            fd.status     = ResRunning;
            fd.deadline   = in_item.now_ms + window;
            fd.last_move  = in_item.now_ms;
            drive_feeder(fd.fwd, in_item.emitters_ok);
            fd.rotor_last = in_item.rotor_level;
            fd.chute_last = in_item.chute_level;
         end
         OpTick: begin
            if (fd.drive == DriveOff) return;
            if (in_item.motor_ma > fd.peak_ma) fd.peak_ma = in_item.motor_ma;

            // The run window has closed.
            if (time_reached(in_item.now_ms, fd.deadline)) begin
               fd.status = (fd.mode == ModeDispense) ? ResTimeout : ResDone;
               halt_feeder();
               return;
            end

            // Rotor rising edge counts as one revolution.
            if (in_item.rotor_level && !fd.rotor_last) begin
               fd.revs      = fd.revs + 16'd1;
               fd.last_move = in_item.now_ms;
            end
            fd.rotor_last = in_item.rotor_level;

            // During a reverse move only the end of the move matters.
            if (fd.reversing) begin
               if (time_reached(in_item.now_ms, fd.reverse_end)) begin
                  fd.reversing = 1'b0;
                  drive_feeder(fd.fwd, in_item.emitters_ok);
                  fd.rotor_last = in_item.rotor_level;
                  fd.chute_last = in_item.chute_level;
                  fd.last_move  = in_item.now_ms;
               end
               return;
            end

            // Chute edge into the active level, outside the refractory window.
            if (fd.mode == ModeDispense
                && in_item.chute_level == settings.chute_active_level
                && fd.chute_last != settings.chute_active_level
                && time_reached(in_item.now_ms, fd.chute_hold)) begin
               if (fd.parcels != 8'hFF) fd.parcels = fd.parcels + 8'd1;
               fd.chute_hold = in_item.now_ms + {16'd0, settings.chute_refractory_ms};
               if (fd.parcels >= fd.target) begin
                  fd.status = ResDone;
                  halt_feeder();
                  return;
               end
            end
            fd.chute_last = in_item.chute_level;

            current_jam = (fd.jam_ma != 16'd0) && (in_item.motor_ma > fd.jam_ma);
            if (fd.mode == ModeDispense) begin
               since   = in_item.now_ms - fd.last_move;
               stalled = (settings.stall_window_ms != 16'd0) && !since[31]
                         && (since > {16'd0, settings.stall_window_ms});
               if (current_jam || stalled) begin
                  if (fd.retries >= settings.max_retries) begin
                     fd.status = ResJam;
                     halt_feeder();
                     return;
                  end
                  fd.retries     = fd.retries + 4'd1;
                  fd.reversing   = 1'b1;
                  fd.reverse_end = in_item.now_ms + {16'd0, settings.reverse_time_ms};
                  drive_feeder(!fd.fwd, in_item.emitters_ok);
                  fd.rotor_last = in_item.rotor_level;
                  fd.last_move  = in_item.now_ms;
               end
            end else if (current_jam) begin
               fd.status = ResJam;
               halt_feeder();
            end
         end
      endcase
   endfunction

   function automatic void check_field(string name, logic [31:0] want_v,
                                       logic [31:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected %0d, actual %0d", name, want_v, got_v);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         fd       = '0;
         fd.fwd   = 1'b1;
         settings.stall_window_ms     = StallWindowReset;
         settings.reverse_time_ms     = ReverseTimeReset;
         settings.max_retries         = MaxRetriesReset;
         settings.chute_refractory_ms = ChuteRefractoryReset;
         settings.chute_active_level  = ChuteActiveReset;
         expected_reports.delete();
      end else begin
         // A result taken at this edge belongs to an item taken earlier.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_reports.size() == 0) begin
               $error("result item arrived with no expectation waiting");
               failures++;
            end else begin
               want = expected_reports.pop_front();
               check_field("motor_drive", 32'(want.motor_drive),
                           32'(rsp_mon.motor_drive));
               check_field("busy_res", 32'(want.busy_res), 32'(rsp_mon.busy_res));
               check_field("result_code", 32'(want.result_code),
                           32'(rsp_mon.result_code));
               check_field("recovering", 32'(want.recovering), 32'(rsp_mon.recovering));
               check_field("parcels_delivered", 32'(want.parcels_delivered),
                           32'(rsp_mon.parcels_delivered));
               check_field("revolutions", 32'(want.revolutions),
                           32'(rsp_mon.revolutions));
               check_field("peak_current_ma", 32'(want.peak_current_ma),
                           32'(rsp_mon.peak_current_ma));
               check_field("retries_used", 32'(want.retries_used),
                           32'(rsp_mon.retries_used));
            end
         end

         // Register writes.
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_index_type'(csr_mon.index))
               CsrStallWindow:     settings.stall_window_ms     = csr_mon.data;
               CsrReverseTime:     settings.reverse_time_ms     = csr_mon.data;
               CsrMaxRetries:      settings.max_retries         = csr_mon.data[3:0];
               CsrChuteRefractory: settings.chute_refractory_ms = csr_mon.data;
               CsrChuteActive:     settings.chute_active_level  = csr_mon.data[0];
               default: ;
            endcase
         end

         // Every accepted input item yields one result.
         if (req_mon.valid && req_mon.ready) begin
            item.operation        = req_mon.operation;
            item.now_ms           = req_mon.now_ms;
            item.rotor_level      = req_mon.rotor_level;
            item.chute_level      = req_mon.chute_level;
            item.motor_ma         = req_mon.motor_ma;
            item.emitters_ok      = req_mon.emitters_ok;
            item.direction        = req_mon.direction;
            item.run_ms           = req_mon.run_ms;
            item.jam_threshold_ma = req_mon.jam_threshold_ma;
            item.parcel_target    = req_mon.parcel_target;
            advance_feeder(item);
            want.motor_drive       = fd.drive;
            want.busy_res          = (fd.drive != DriveOff);
            want.result_code       = fd.status;
            want.recovering        = fd.reversing;
            want.parcels_delivered = fd.parcels;
            want.revolutions       = fd.revs;
            want.peak_current_ma   = fd.peak_ma;
            want.retries_used      = fd.retries;
            expected_reports.push_back(want);
         end
      end
      awaiting_count <= expected_reports.size();
   end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

// Drives the feeder motor controller with start, tick and stop items and
// register writes, with random gaps on both channels, and reports the verdict
// from the failure count of the checker.
module tb_top;
   import dmjc_pkg::*;

   localparam int WatchdogLimit = 4000;
   localparam int HoldOffCycles = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int          check_failures;
   int          results_awaited;
   int          items_sent = 0;
   int          idle_cycles = 0;
   logic [31:0] clock_ms = 32'd0;
   bit          req_calm = 1'b0;
   bit          rsp_calm = 1'b0;
   bit          hold_off_request = 1'b0;

   dmjc_req_if req_ch();
   dmjc_rsp_if rsp_ch();
   dmjc_csr_if csr_ch();

   dispense_motor_jam_controller dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr(csr_ch)
   );

   dmjc_feeder_checker feeder_check (
      .clock(clock),
      .reset(reset),
      .req_mon(req_ch),
      .rsp_mon(rsp_ch),
      .csr_mon(csr_ch),
      .mismatch_count(check_failures),
      .awaiting_count(results_awaited)
   );

   always #1 clock = ~clock;

   function automatic req_type make_item(op_type op, logic [31:0] now, logic rotor,
                                         logic chute, logic [15:0] ma, logic ok,
                                         logic dir, logic [31:0] run, logic [15:0] jam,
                                         logic [7:0] target);
      req_type r;
      r.operation        = op;
      r.now_ms           = now;
      r.rotor_level      = rotor;
      r.chute_level      = chute;
      r.motor_ma         = ma;
      r.emitters_ok      = ok;
      r.direction        = dir;
      r.run_ms           = run;
      r.jam_threshold_ma = jam;
      r.parcel_target    = target;
      return r;
   endfunction

   // Offers one item after a random gap and waits until it is taken.
   task automatic send_item(req_type r);
      int gap;
      if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
      gap = req_calm ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid            <= 1'b1;
      req_ch.operation        <= r.operation;
      req_ch.now_ms           <= r.now_ms;
      req_ch.rotor_level      <= r.rotor_level;
      req_ch.chute_level      <= r.chute_level;
      req_ch.motor_ma         <= r.motor_ma;
      req_ch.emitters_ok      <= r.emitters_ok;
      req_ch.direction        <= r.direction;
      req_ch.run_ms           <= r.run_ms;
      req_ch.jam_threshold_ma <= r.jam_threshold_ma;
      req_ch.parcel_target    <= r.parcel_target;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   // Stops offering and waits until every expected result has come back.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (results_awaited != 0);
   endtask

   task automatic write_register(csr_index_type idx, logic [15:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   task automatic program_registers(logic [15:0] stall, logic [15:0] reverse,
                                    logic [15:0] retries, logic [15:0] refractory,
                                    logic [15:0] active);
      wait_drained();
      write_register(CsrStallWindow, stall);
      write_register(CsrReverseTime, reverse);
      write_register(CsrMaxRetries, retries);
      write_register(CsrChuteRefractory, refractory);
      write_register(CsrChuteActive, active);
      csr_ch.valid <= 1'b0;
   endtask

   // One operation: a start followed by ticks with plausible sensor traffic,
   // or now and then a lone stop or a fully random item.
   task automatic run_episode();
      int          kind;
      int          ticks;
      logic [31:0] step;
      logic [15:0] jam;
      logic [15:0] ma;
      logic        rotor;
      logic        ok;
      logic        stuck;
      op_type      op;
      kind = $urandom_range(0, 19);
      if (kind < 2) begin
         send_item(make_item(op_type'(2'($urandom_range(0, 3))), $urandom, 1'($urandom),
                             1'($urandom), 16'($urandom), 1'($urandom), 1'($urandom),
                             $urandom, 16'($urandom), 8'($urandom)));
         return;
      end
      if (kind == 2) begin
         send_item(make_item(OpStop, clock_ms, 1'($urandom), 1'($urandom), 16'($urandom),
                             1'($urandom), 1'($urandom), $urandom, 16'($urandom),
                             8'($urandom)));
         return;
      end

      op = (kind < 14) ? OpDispense : OpRun;
      case ($urandom_range(0, 9))
         0:       jam = 16'($urandom);
         1, 2, 3: jam = 16'd0;
         default: jam = 16'($urandom_range(100, 2000));
      endcase
      rotor = 1'($urandom);
      ok    = ($urandom_range(0, 24) != 0);
      clock_ms += $urandom_range(0, 50);
      send_item(make_item(op, clock_ms, rotor, 1'($urandom), 16'($urandom_range(0, 3000)),
                          ok, 1'($urandom),
                          ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 3000),
                          jam,
                          ($urandom_range(0, 19) == 0) ? 8'($urandom)
                                                       : 8'($urandom_range(0, 6))));

      // A stuck rotor rarely moves, which lets the stall check fire.
      stuck = ($urandom_range(0, 2) == 0);
      ticks = $urandom_range(1, 40);
      repeat (ticks) begin
         step = ($urandom_range(0, 29) == 0) ? $urandom : $urandom_range(0, 40);
         clock_ms += step;
         if (!stuck || $urandom_range(0, 9) == 0) rotor = 1'($urandom);
         if (jam == 16'd0) ma = 16'($urandom);
         else if ($urandom_range(0, 9) == 0) ma = jam + 16'($urandom_range(0, 300));
         else ma = 16'($urandom_range(0, jam));
         ok = ($urandom_range(0, 29) != 0);
         send_item(make_item(OpTick, clock_ms, rotor, $urandom_range(0, 2) == 0, ma, ok,
                             1'($urandom), $urandom, 16'($urandom), 8'($urandom)));
      end
      if ($urandom_range(0, 5) == 0) begin
         send_item(make_item(OpStop, clock_ms, rotor, 1'b0, 16'd0, 1'b1, 1'b0, 32'd0,
                             16'd0, 8'd0));
      end
   endtask

   task automatic run_random_items(int count);
      int goal;
      goal = items_sent + count;
      while (items_sent < goal) run_episode();
   endtask

   // Result receiver: random stalls per item, with a long hold-off on request.
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HoldOffCycles) @(posedge clock);
         end
         if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
         stall = rsp_calm ? 0 : $urandom_range(0, 14);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // Ends the run when no channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_ch.valid            <= 1'b0;
      req_ch.operation        <= OpTick;
      req_ch.now_ms           <= 32'd0;
      req_ch.rotor_level      <= 1'b0;
      req_ch.chute_level      <= 1'b0;
      req_ch.motor_ma         <= 16'd0;
      req_ch.emitters_ok      <= 1'b0;
      req_ch.direction        <= 1'b0;
      req_ch.run_ms           <= 32'd0;
      req_ch.jam_threshold_ma <= 16'd0;
      req_ch.parcel_target    <= 8'd0;
      csr_ch.valid            <= 1'b0;
      csr_ch.index            <= CsrStallWindow;
      csr_ch.data             <= 16'd0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed items under the reset register values.
      // Tick while stopped with every field but emitter power at its top value, then stop while idle.
      send_item(make_item(OpTick, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF, 1'b0, 1'b1,
                          32'hFFFF_FFFF, 16'hFFFF, 8'hFF));
      send_item(make_item(OpStop, 32'd0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 32'd0, 16'd0, 8'd0));
      // Timed run with a clamped window, a rotor edge, then a current jam.
      send_item(make_item(OpRun, 32'd1000, 1'b0, 1'b0, 16'd0, 1'b1, 1'b1, 32'hFFFF_FFFF,
                          16'd500, 8'd0));
      send_item(make_item(OpTick, 32'd1010, 1'b1, 1'b0, 16'd400, 1'b1, 1'b0, 32'd0, 16'd0,
                          8'd0));
      send_item(make_item(OpTick, 32'd1020, 1'b0, 1'b0, 16'd600, 1'b1, 1'b0, 32'd0, 16'd0,
                          8'd0));
      // Zero run window times out on the first tick.
      send_item(make_item(OpDispense, 32'd1100, 1'b0, 1'b0, 16'd0, 1'b1, 1'b0, 32'd0,
                          16'd0, 8'd5));
      send_item(make_item(OpTick, 32'd1100, 1'b0, 1'b0, 16'd0, 1'b1, 1'b0, 32'd0, 16'd0,
                          8'd0));
      // Start refused for bad emitter power.
      send_item(make_item(OpDispense, 32'd1200, 1'b0, 1'b0, 16'd0, 1'b0, 1'b1, 32'd5000,
                          16'd0, 8'd3));
      // Parcel target zero: the first parcel completes the dispense.
      send_item(make_item(OpDispense, 32'd2000, 1'b0, 1'b0, 16'd0, 1'b1, 1'b1, 32'd5000,
                          16'd0, 8'd0));
      send_item(make_item(OpTick, 32'd2010, 1'b0, 1'b1, 16'd100, 1'b1, 1'b0, 32'd0, 16'd0,
                          8'd0));
      // Current jam starts a reverse move; the resume forward is refused.
      send_item(make_item(OpDispense, 32'd3000, 1'b0, 1'b0, 16'd0, 1'b1, 1'b0, 32'd50000,
                          16'd300, 8'd2));
      send_item(make_item(OpTick, 32'd3010, 1'b0, 1'b0, 16'd400, 1'b1, 1'b0, 32'd0, 16'd0,
                          8'd0));
      send_item(make_item(OpTick, 32'd3100, 1'b1, 1'b0, 16'd50, 1'b1, 1'b0, 32'd0, 16'd0,
                          8'd0));
      send_item(make_item(OpTick, 32'd3420, 1'b0, 1'b0, 16'd50, 1'b0, 1'b0, 32'd0, 16'd0,
                          8'd0));
      // One parcel, a second chute edge inside the refractory window, then a jam
      // whose reverse move is refused.
      send_item(make_item(OpDispense, 32'd4000, 1'b0, 1'b0, 16'd0, 1'b1, 1'b1, 32'd50000,
                          16'd300, 8'd3));
      send_item(make_item(OpTick, 32'd4010, 1'b0, 1'b1, 16'd10, 1'b1, 1'b0, 32'd0, 16'd0,
                          8'd0));
      send_item(make_item(OpTick, 32'd4020, 1'b0, 1'b0, 16'd10, 1'b1, 1'b0, 32'd0, 16'd0,
                          8'd0));
      send_item(make_item(OpTick, 32'd4030, 1'b0, 1'b1, 16'd10, 1'b1, 1'b0, 32'd0, 16'd0,
                          8'd0));
      send_item(make_item(OpTick, 32'd4040, 1'b0, 1'b0, 16'd301, 1'b0, 1'b0, 32'd0, 16'd0,
                          8'd0));
      // Deadline that wraps past zero.
      send_item(make_item(OpRun, 32'hFFFF_FF00, 1'b0, 1'b0, 16'd0, 1'b1, 1'b0, 32'h200,
                          16'd0, 8'd0));
      send_item(make_item(OpTick, 32'h50, 1'b1, 1'b0, 16'd20, 1'b1, 1'b0, 32'd0, 16'd0,
                          8'd0));
      send_item(make_item(OpTick, 32'h120, 1'b0, 1'b0, 16'd20, 1'b1, 1'b0, 32'd0, 16'd0,
                          8'd0));
      // Restart while running, then abort while running.
      send_item(make_item(OpRun, 32'd5000, 1'b0, 1'b0, 16'd0, 1'b1, 1'b1, 32'd1000, 16'd0,
                          8'd0));
      send_item(make_item(OpDispense, 32'd5010, 1'b1, 1'b1, 16'd0, 1'b1, 1'b0, 32'd1000,
                          16'd0, 8'd4));
      send_item(make_item(OpStop, 32'd5020, 1'b0, 1'b0, 16'd0, 1'b1, 1'b0, 32'd0, 16'd0,
                          8'd0));

      // Short windows so stalls and reverse moves happen often; a long result
      // hold-off midway backs the block up.
      program_registers(16'd120, 16'd80, 16'd3, 16'd150, 16'd1);
      clock_ms = $urandom;
      run_random_items(60);
      hold_off_request = 1'b1;
      run_random_items(200);

      // All registers at their low end: no stall check, no retries, no
      // refractory window, chute active low.
      program_registers(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      clock_ms = $urandom;
      run_random_items(260);
      // Dispense long enough to reach the top parcel count.
      clock_ms += 100;
      send_item(make_item(OpDispense, clock_ms, 1'b0, 1'b1, 16'd0, 1'b1, 1'b1, 32'd60000,
                          16'd0, 8'd255));
      for (int k = 0; k < 512; k++) begin
         clock_ms += 1;
         send_item(make_item(OpTick, clock_ms, k[1], k[0], 16'($urandom), 1'b1,
                             1'($urandom), $urandom, 16'($urandom), 8'($urandom)));
      end

      // All registers at their high end, with time wrapping early on.
      program_registers(16'hFFFF, 16'hFFFF, 16'd15, 16'hFFFF, 16'd1);
      clock_ms = 32'hFFFF_F000;
      run_random_items(260);

      // Random settings in the useful range, with a full drain midway.
      program_registers(16'($urandom_range(1, 400)), 16'($urandom_range(0, 300)),
                        16'($urandom_range(0, 15)), 16'($urandom_range(0, 500)),
                        16'($urandom_range(0, 1)));
      clock_ms = $urandom;
      run_random_items(130);
      wait_drained();
      run_random_items(130);

      // Fully random write data.
      program_registers(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom));
      clock_ms = $urandom;
      run_random_items(260);

      wait_drained();
      repeat (8) @(posedge clock);
      if (check_failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
